@@ src/nlv_pkg.sv @@
// ============================================================================
// nlv_pkg
// shared types and constants of the decimal number literal validator
// ============================================================================
package nlv_pkg;

    // input transaction: one character of the number string
    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       last;
    } t_in_item;

    // result transaction: one status per string
    typedef struct packed {
        logic [2:0] status;
        logic [6:0] mantissa_digits;
        logic [4:0] exponent_digits;
    } t_out_item;

    // configuration register file
    typedef struct packed {
        logic       real_mode;
        logic [5:0] max_mantissa_digits;
        logic [3:0] max_exponent_digits;
    } t_cfg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_REAL_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MANT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_EXP   = 2'd2;

    localparam logic       RST_REAL_MODE = 1'b1;
    localparam logic [5:0] RST_MAX_MANT  = 6'd30;
    localparam logic [3:0] RST_MAX_EXP   = 4'd5;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_BAD      = 3'd2;
    localparam logic [2:0] ST_TOO_LONG = 3'd3;
    localparam logic [2:0] ST_ZERO     = 3'd4;

    // saturation points of the digit counters
    localparam logic [6:0] MANT_SAT = 7'd64;
    localparam logic [4:0] EXP_SAT  = 5'd16;

    // characters of interest
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;
    localparam logic [7:0] CHR_PLUS  = 8'h2B;
    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_POINT = 8'h2E;
    localparam logic [7:0] CHR_LOW_E = 8'h65;
    localparam logic [7:0] CHR_UP_E  = 8'h45;

    // character class found by the front end
    typedef enum logic [2:0] {
        CLS_DIGIT   = 3'd0,
        CLS_SIGN    = 3'd1,
        CLS_POINT   = 3'd2,
        CLS_EXPMARK = 3'd3,
        CLS_OTHER   = 3'd4
    } t_cls;

    // classified character as queued between front and back
    typedef struct packed {
        t_cls cls;
        logic is_zero;
        logic has_char;
        logic last;
    } t_token;

    // token channel from front to back
    typedef struct packed {
        logic   valid;
        t_token tok;
    } t_tok_chan;

    localparam int TOKQ_DEPTH = 4;
    localparam int TOKQ_PTR_W = 2;
    localparam int TOKQ_CNT_W = 3;

    localparam int RESQ_DEPTH = 2;
    localparam int RESQ_PTR_W = 1;
    localparam int RESQ_CNT_W = 2;

    // parser phase
    typedef enum logic [4:0] {
        PH_START  = 5'b00001,
        PH_INT    = 5'b00010,
        PH_FRAC   = 5'b00100,
        PH_ESTART = 5'b01000,
        PH_EXP    = 5'b10000
    } t_phase;

endpackage

@@ src/number_literal_validator.sv @@
// ============================================================================
// number_literal_validator
// checks decimal number strings one character at a time
// ============================================================================
// Characters enter through a queue-style port (push/full) at up to one per
// cycle; a front end classifies each character and places it in a four-entry
// token queue, and a back end steps the number grammar one token per cycle
// while the result queue has room for a last token, so the sustained rate is
// one character per clock. A character is registered in the token queue
// before it reaches the grammar state, and a string's status lands on the
// result port (empty/pop) at the same edge at which its last transaction
// leaves the token queue. Each string gives exactly one result transaction,
// on the transaction with last set; a transaction with has_char low adds no
// character. The result queue holds two statuses, so a stalled consumer backs
// up first the token queue and then the input. Configuration writes
// (real_mode, max mantissa digits, max exponent digits) take effect at once
// and are meant for idle periods.
// ============================================================================
module number_literal_validator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input transactions
    input  logic                              push,
    output logic                              full,
    input  nlv_pkg::t_in_item                 i_item,
    // result transactions
    output logic                              empty,
    input  logic                              pop,
    output nlv_pkg::t_out_item                o_result,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [nlv_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [nlv_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import nlv_pkg::*;

    t_cfg      r_cfg;
    t_tok_chan w_tok;
    logic      w_tok_pop;

    // configuration registers, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.real_mode           <= RST_REAL_MODE;
            r_cfg.max_mantissa_digits <= RST_MAX_MANT;
            r_cfg.max_exponent_digits <= RST_MAX_EXP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_REAL_MODE: r_cfg.real_mode           <= i_cfg_wdata[0];
                CFG_MAX_MANT:  r_cfg.max_mantissa_digits <= i_cfg_wdata[5:0];
                CFG_MAX_EXP:   r_cfg.max_exponent_digits <= i_cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    // front end: classify and buffer characters
    nlv_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_item    (i_item),
        .o_tok     (w_tok),
        .i_tok_pop (w_tok_pop)
    );

    // back end: grammar walk and result queue
    nlv_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_tok     (w_tok),
        .o_tok_pop (w_tok_pop),
        .empty     (empty),
        .pop       (pop),
        .o_result  (o_result)
    );

endmodule

@@ src/nlv_front.sv @@
// ============================================================================
// nlv_front
// classifies each accepted character and holds it in a short token queue
// ============================================================================
module nlv_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  nlv_pkg::t_in_item i_item,
    output nlv_pkg::t_tok_chan o_tok,
    input  logic              i_tok_pop
);
    import nlv_pkg::*;

    t_token                r_mem [TOKQ_DEPTH];
    logic [TOKQ_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [TOKQ_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [TOKQ_CNT_W-1:0] r_cnt, n_cnt;
    t_token                w_tok;
    logic                  w_wr;
    logic                  w_rd;

    // character classification
    always_comb begin
        w_tok.has_char = i_item.has_char;
        w_tok.last     = i_item.last;
        w_tok.is_zero  = (i_item.ch == CHR_ZERO);
        unique case (i_item.ch) inside
            [CHR_ZERO:CHR_NINE]:  w_tok.cls = CLS_DIGIT;
            CHR_PLUS, CHR_MINUS:  w_tok.cls = CLS_SIGN;
            CHR_POINT:            w_tok.cls = CLS_POINT;
            CHR_LOW_E, CHR_UP_E:  w_tok.cls = CLS_EXPMARK;
            default:              w_tok.cls = CLS_OTHER;
        endcase
    end

    assign full = (r_cnt == TOKQ_CNT_W'(TOKQ_DEPTH));
    assign w_wr = push && !full;
    assign w_rd = i_tok_pop && (r_cnt != '0);

    assign o_tok.valid = (r_cnt != '0);
    assign o_tok.tok   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = w_wr ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_rd ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_cnt    = r_cnt + TOKQ_CNT_W'(w_wr) - TOKQ_CNT_W'(w_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= w_tok;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= TOKQ_CNT_W'(TOKQ_DEPTH))
        else $error("token queue count out of range");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 || r_cnt == TOKQ_CNT_W'(TOKQ_DEPTH)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("token queue pointers disagree with count");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tok_pop |-> o_tok.valid)
        else $error("token popped from empty queue");

endmodule

@@ src/nlv_back.sv @@
// ============================================================================
// nlv_back
// walks the grammar one token per cycle while results fit; queues the statuses
// ============================================================================
module nlv_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nlv_pkg::t_cfg      i_cfg,
    input  nlv_pkg::t_tok_chan i_tok,
    output logic               o_tok_pop,
    output logic               empty,
    input  logic               pop,
    output nlv_pkg::t_out_item o_result
);
    import nlv_pkg::*;

    t_phase     r_phase, n_phase;
    logic [6:0] r_mant, n_mant;
    logic [4:0] r_exp, n_exp;
    logic       r_phd, n_phd;
    logic       r_bad, n_bad;
    logic       r_zero, n_zero;
    logic [1:0] r_seen, n_seen;

    t_out_item             r_res [RESQ_DEPTH];
    logic [RESQ_PTR_W-1:0] r_wr_ptr;
    logic [RESQ_PTR_W-1:0] r_rd_ptr;
    logic [RESQ_CNT_W-1:0] r_cnt;

    t_token    w_tok;
    logic      w_take;
    logic      w_res_push;
    logic      w_res_pop;
    t_out_item w_res;

    assign w_tok      = i_tok.tok;
    // a last token needs room for its result
    assign w_take     = i_tok.valid &&
                        (!w_tok.last || r_cnt != RESQ_CNT_W'(RESQ_DEPTH));
    assign o_tok_pop  = w_take;
    assign w_res_push = w_take && w_tok.last;
    assign w_res_pop  = pop && !empty;

    always_comb begin
        n_phase = r_phase;
        n_mant  = r_mant;
        n_exp   = r_exp;
        n_phd   = r_phd;
        n_bad   = r_bad;
        n_zero  = r_zero;
        n_seen  = r_seen;

        if (w_tok.has_char) begin
            if (r_seen == 2'd0) begin
                n_zero = w_tok.is_zero;
            end
            if (r_seen != 2'd3) begin
                n_seen = r_seen + 2'd1;
            end
            if (!r_bad) begin
                case (w_tok.cls)
                    CLS_DIGIT: begin
                        n_phd = 1'b1;
                        if (r_phase == PH_START || r_phase == PH_INT ||
                            r_phase == PH_FRAC) begin
                            if (r_phase == PH_START) begin
                                n_phase = PH_INT;
                            end
                            if (r_mant != MANT_SAT) begin
                                n_mant = r_mant + 7'd1;
                            end
                        end else begin
                            n_phase = PH_EXP;
                            if (r_exp != EXP_SAT) begin
                                n_exp = r_exp + 5'd1;
                            end
                        end
                    end
                    CLS_SIGN: begin
                        if (r_phase == PH_START) begin
                            n_phase = PH_INT;
                        end else if (r_phase == PH_ESTART && i_cfg.real_mode) begin
                            n_phase = PH_EXP;
                        end else begin
                            n_bad = 1'b1;
                        end
                    end
                    CLS_POINT: begin
                        if (i_cfg.real_mode && r_phase == PH_INT && r_phd) begin
                            n_phase = PH_FRAC;
                            n_phd   = 1'b0;
                        end else begin
                            n_bad = 1'b1;
                        end
                    end
                    CLS_EXPMARK: begin
                        if (i_cfg.real_mode && r_phd &&
                            (r_phase == PH_INT || r_phase == PH_FRAC)) begin
                            n_phase = PH_ESTART;
                            n_phd   = 1'b0;
                        end else begin
                            n_bad = 1'b1;
                        end
                    end
                    default: begin
                        n_bad = 1'b1;
                    end
                endcase
            end
        end

        // status from the state after this token
        if (n_seen == 2'd0) begin
            w_res.status = ST_EMPTY;
        end else if (n_bad || !n_phd) begin
            w_res.status = ST_BAD;
        end else if (n_mant > {1'b0, i_cfg.max_mantissa_digits} ||
                     n_exp > {1'b0, i_cfg.max_exponent_digits}) begin
            w_res.status = ST_TOO_LONG;
        end else if (!i_cfg.real_mode && n_seen == 2'd1 && n_zero) begin
            w_res.status = ST_ZERO;
        end else begin
            w_res.status = ST_OK;
        end
        w_res.mantissa_digits = n_mant;
        w_res.exponent_digits = i_cfg.real_mode ? n_exp : 5'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_mant  <= '0;
            r_exp   <= '0;
            r_phd   <= 1'b0;
            r_bad   <= 1'b0;
            r_zero  <= 1'b0;
            r_seen  <= '0;
        end else if (w_take) begin
            if (w_tok.last) begin
                r_phase <= PH_START;
                r_mant  <= '0;
                r_exp   <= '0;
                r_phd   <= 1'b0;
                r_bad   <= 1'b0;
                r_zero  <= 1'b0;
                r_seen  <= '0;
            end else begin
                r_phase <= n_phase;
                r_mant  <= n_mant;
                r_exp   <= n_exp;
                r_phd   <= n_phd;
                r_bad   <= n_bad;
                r_zero  <= n_zero;
                r_seen  <= n_seen;
            end
        end
    end

    // result queue
    assign empty    = (r_cnt == '0);
    assign o_result = r_res[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_res_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_res_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_cnt <= r_cnt + RESQ_CNT_W'(w_res_push) - RESQ_CNT_W'(w_res_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_push) begin
            r_res[r_wr_ptr] <= w_res;
        end
    end

    a_res_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= RESQ_CNT_W'(RESQ_DEPTH))
        else $error("result queue count out of range");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_tok.last) |=> (r_seen == 2'd0 && !r_bad && r_phase == PH_START))
        else $error("string state not cleared after last token");

    a_frozen_when_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bad && w_take && !w_tok.last) |=>
            ($stable(r_mant) && $stable(r_exp) && $stable(r_phase)))
        else $error("counts moved after a bad symbol");

endmodule

@@ tb/sv/number_literal_validator_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// number_literal_validator_tb
// self-checking bench for the decimal number literal validator
// ============================================================================
// Character transactions go in through the push/full port and status
// transactions come back through the empty/pop port. Both sides idle and
// stall at random. A scoreboard runs its own copy of the number grammar on
// every accepted character and queues the status that each string should
// give. Every popped result is checked field by field against the oldest
// queued status. The run opens with a few directed strings. It then steps
// through a series of register settings, the extremes among them, and sends
// random strings under each one: mostly well-formed numbers, plus mutated,
// truncated, empty and zero-like strings and raw byte noise.
// ============================================================================
module number_literal_validator_tb;
    import nlv_pkg::*;

    localparam int GAP_MAX        = 6;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int END_CYCLES     = 20;
    localparam int RAND_ITEMS     = 1650;
    localparam int N_SETTINGS     = 7;
    localparam int MAX_PRINTED    = 100;

    // register index past the three real registers, must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    // ------------------------------------------------------------------------
    // scoreboard: grammar copy plus the queue of statuses still to come
    // ------------------------------------------------------------------------
    class literal_scoreboard;
        t_cfg       cfg;
        t_phase     ph;
        logic [6:0] mant_cnt;
        logic [4:0] exp_cnt;
        logic       part_digit;
        logic       bad;
        logic       lone_zero;
        logic [1:0] seen;
        t_out_item  expected_status[$];
        int         fail_cnt;

        function new();
            cfg.real_mode           = RST_REAL_MODE;
            cfg.max_mantissa_digits = RST_MAX_MANT;
            cfg.max_exponent_digits = RST_MAX_EXP;
            fail_cnt = 0;
            clear_string();
        endfunction

        function void clear_string();
            ph         = PH_START;
            mant_cnt   = '0;
            exp_cnt    = '0;
            part_digit = 1'b0;
            bad        = 1'b0;
            lone_zero  = 1'b0;
            seen       = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_REAL_MODE: cfg.real_mode           = data[0];
                CFG_MAX_MANT:  cfg.max_mantissa_digits = data;
                CFG_MAX_EXP:   cfg.max_exponent_digits = data[3:0];
                default: ;
            endcase
        endfunction

        // one character through the grammar
        function void step_grammar(logic [7:0] c);
            logic is_digit;
            logic is_sign;
            is_digit = (c >= CHR_ZERO) && (c <= CHR_NINE);
            is_sign  = (c == CHR_PLUS) || (c == CHR_MINUS);
            if (seen == 2'd0)
                lone_zero = (c == CHR_ZERO);
            if (seen != 2'd3)
                seen = seen + 2'd1;
            if (bad)
                return;
            if (is_digit) begin
                if (ph == PH_START || ph == PH_INT || ph == PH_FRAC) begin
                    if (ph == PH_START)
                        ph = PH_INT;
                    if (mant_cnt < MANT_SAT)
                        mant_cnt = mant_cnt + 7'd1;
                end else begin
                    ph = PH_EXP;
                    if (exp_cnt < EXP_SAT)
                        exp_cnt = exp_cnt + 5'd1;
                end
                part_digit = 1'b1;
            end else if (is_sign) begin
                if (ph == PH_START)
                    ph = PH_INT;
                else if (ph == PH_ESTART && cfg.real_mode)
                    ph = PH_EXP;
                else
                    bad = 1'b1;
            end else if (c == CHR_POINT) begin
                if (cfg.real_mode && ph == PH_INT && part_digit) begin
                    ph         = PH_FRAC;
                    part_digit = 1'b0;
                end else begin
                    bad = 1'b1;
                end
            end else if (c == CHR_LOW_E || c == CHR_UP_E) begin
                if (cfg.real_mode && (ph == PH_INT || ph == PH_FRAC) && part_digit) begin
                    ph         = PH_ESTART;
                    part_digit = 1'b0;
                end else begin
                    bad = 1'b1;
                end
            end else begin
                bad = 1'b1;
            end
        endfunction

        // accepted input transaction; a last one closes the string
        function void note_char(t_in_item it);
            t_out_item st;
            if (it.has_char)
                step_grammar(it.ch);
            if (!it.last)
                return;
            if (seen == 2'd0)
                st.status = ST_EMPTY;
            else if (bad || !part_digit)
                st.status = ST_BAD;
            else if (mant_cnt > cfg.max_mantissa_digits || exp_cnt > cfg.max_exponent_digits)
                st.status = ST_TOO_LONG;
            else if (!cfg.real_mode && seen == 2'd1 && lone_zero)
                st.status = ST_ZERO;
            else
                st.status = ST_OK;
            st.mantissa_digits = mant_cnt;
            st.exponent_digits = cfg.real_mode ? exp_cnt : 5'd0;
            expected_status.push_back(st);
            clear_string();
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        // printing stops after a while so a broken design cannot flood the log
        task report(string msg);
            fail_cnt++;
            if (fail_cnt <= MAX_PRINTED)
                $display("%0t ns  mismatch: %s", $realtime, msg);
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (expected_status.size() == 0) begin
                report($sformatf("result with no string pending (status %0d)", got.status));
                return;
            end
            want = expected_status.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.mantissa_digits !== want.mantissa_digits)
                report($sformatf("mantissa_digits %0d, expected %0d",
                                 got.mantissa_digits, want.mantissa_digits));
            if (got.exponent_digits !== want.exponent_digits)
                report($sformatf("exponent_digits %0d, expected %0d",
                                 got.exponent_digits, want.exponent_digits));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // signals and the block
    // ------------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    t_in_item              i_item;
    logic                  empty;
    logic                  pop;
    t_out_item             o_result;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    literal_scoreboard sb = new();

    logic [7:0] txt[$];      // string under construction
    int         items_sent;  // every accepted input transaction
    int         tx_count;
    int         rx_count;
    bit         tx_steady;   // sender runs without gaps for a stretch
    bit         rx_steady;   // receiver pops without stalls for a stretch
    int         quiet_cycles;

    number_literal_validator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any transaction on either side
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns  watchdog: no transaction for %0d cycles",
                     $realtime, WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // one input transaction, after a random gap; push stays high on return
    task automatic send_item(logic [7:0] c, logic has, logic fin);
        t_in_item it;
        int       gap;
        it.ch       = c;
        it.has_char = has;
        it.last     = fin;
        gap = tx_steady ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do begin
            @(posedge i_clk);
        end while (full);
        sb.note_char(it);
        items_sent++;
        tx_count++;
        if (tx_count % 40 == 0)
            tx_steady = ($urandom_range(0, 3) == 0);
    endtask

    // stop sending and wait until every pending status has been popped
    task automatic wait_idle(int settle);
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // one register write; we drops again for a cycle before the next one
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // all three registers; unused data bits get junk, the block must mask them
    task automatic write_setting(logic rmode, logic [5:0] mant, logic [3:0] expo);
        write_reg(CFG_REAL_MODE, {5'($urandom_range(0, 31)), rmode});
        write_reg(CFG_MAX_MANT, mant);
        write_reg(CFG_MAX_EXP, {2'($urandom_range(0, 3)), expo});
    endtask

    // send txt as one string; sometimes with ignored transactions in between
    // and sometimes closed by a terminator without a character
    task automatic send_txt();
        bit term;
        term = (txt.size() == 0) || ($urandom_range(0, 7) == 0);
        foreach (txt[i]) begin
            if ($urandom_range(0, 9) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(txt[i], 1'b1, !term && (i == txt.size() - 1));
        end
        if (term)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // string generators
    // ------------------------------------------------------------------------
    function automatic void load_text(string s);
        txt.delete();
        for (int k = 0; k < s.len(); k++)
            txt.push_back(s[k]);
    endfunction

    function automatic void add_digits(int n);
        for (int k = 0; k < n; k++)
            txt.push_back(CHR_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    function automatic void add_sign();
        case ($urandom_range(0, 2))
            0: txt.push_back(CHR_PLUS);
            1: txt.push_back(CHR_MINUS);
            default: ;
        endcase
    endfunction

    // digit count: mostly short, often right at the limit, rarely past saturation
    function automatic int draw_len(int lim, int sat);
        int r;
        int lo;
        r  = $urandom_range(0, 99);
        lo = (lim > 1) ? lim - 1 : 1;
        if (r < 65)
            return $urandom_range(1, 5);
        if (r < 88)
            return $urandom_range(lo, lim + 1);
        if (r < 97)
            return $urandom_range(1, 12);
        return $urandom_range(sat - 1, sat + 3);
    endfunction

    function automatic void build_well_formed(bit real_syntax);
        int n;
        int ip;
        txt.delete();
        add_sign();
        n = draw_len(sb.cfg.max_mantissa_digits, MANT_SAT);
        if (real_syntax && $urandom_range(0, 1)) begin
            // integer part, point, fraction
            if (n >= 2) begin
                ip = $urandom_range(1, n - 1);
            end else begin
                ip = 1;
                n  = 1 + $urandom_range(1, 3);
            end
            add_digits(ip);
            txt.push_back(CHR_POINT);
            add_digits(n - ip);
        end else begin
            add_digits(n);
        end
        if (real_syntax && $urandom_range(0, 1)) begin
            txt.push_back($urandom_range(0, 1) ? CHR_LOW_E : CHR_UP_E);
            add_sign();
            add_digits(draw_len(sb.cfg.max_exponent_digits, EXP_SAT));
        end
    endfunction

    function automatic logic [7:0] noise_char();
        case ($urandom_range(0, 7))
            0: return CHR_POINT;
            1: return CHR_LOW_E;
            2: return CHR_UP_E;
            3: return CHR_PLUS;
            4: return CHR_MINUS;
            5: return CHR_ZERO + 8'($urandom_range(0, 9));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // replace, insert or drop one character somewhere
    function automatic void mutate();
        int pos;
        pos = $urandom_range(0, txt.size());
        case ($urandom_range(0, 2))
            0: begin
                if (pos < txt.size())
                    txt[pos] = noise_char();
                else
                    txt.push_back(noise_char());
            end
            1: txt.insert(pos, noise_char());
            default: begin
                if (pos < txt.size())
                    txt.delete(pos);
            end
        endcase
    endfunction

    // cut right after the last non-digit: sign, point or e left with nothing after
    function automatic void truncate_part();
        int cut;
        cut = -1;
        foreach (txt[i])
            if (txt[i] < CHR_ZERO || txt[i] > CHR_NINE)
                cut = i;
        if (cut >= 0) begin
            txt = txt[0:cut];
        end else begin
            txt.delete();
            txt.push_back($urandom_range(0, 1) ? CHR_PLUS : CHR_MINUS);
        end
    endfunction

    task automatic send_random_string();
        int r;
        bit real_syntax;
        r = $urandom_range(0, 99);
        real_syntax = sb.cfg.real_mode || ($urandom_range(0, 4) == 0);
        if (r < 58) begin
            build_well_formed(real_syntax);
        end else if (r < 78) begin
            build_well_formed(real_syntax);
            repeat ($urandom_range(1, 2)) mutate();
        end else if (r < 86) begin
            build_well_formed(1'b1);
            truncate_part();
        end else if (r < 90) begin
            txt.delete();
        end else if (r < 95) begin
            // zero look-alikes: only a lone zero in integer mode is status zero
            case ($urandom_range(0, 5))
                0: load_text("0");
                1: load_text("00");
                2: load_text("-0");
                3: load_text("+0");
                4: load_text("0.0");
                default: load_text("0e0");
            endcase
        end else begin
            txt.delete();
            repeat ($urandom_range(1, 4)) txt.push_back(8'($urandom_range(0, 255)));
        end
        send_txt();
    endtask

    // ------------------------------------------------------------------------
    // result side: pop with random stalls, check every result transaction
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, GAP_MAX);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do begin
                @(posedge i_clk);
            end while (empty);
            sb.check_result(o_result);
            rx_count++;
            if (rx_count % 37 == 0)
                rx_steady = ($urandom_range(0, 3) == 0);
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int target;
        push        <= 1'b0;
        i_item      <= '0;
        pop         <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= '0;
        i_cfg_wdata <= '0;
        i_rst_n     <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed strings under the reset setting (real mode, 30 / 5)
        send_item(8'h00, 1'b0, 1'b1);               // empty string
        load_text("-12.5E+7"); send_txt();          // full real number
        load_text("+");        send_txt();          // sign with no digits
        load_text("9e");       send_txt();          // e with no exponent
        load_text("1.");       send_txt();          // point with no fraction
        load_text(".5");       send_txt();          // no integer part
        send_item(8'hFF, 1'b1, 1'b1);               // top byte value
        send_item(8'h5A, 1'b0, 1'b0);               // ignored transaction
        send_item(CHR_NINE, 1'b1, 1'b1);
        load_text("0");        send_txt();          // plain ok in real mode
        wait_idle(SETTLE_CYCLES);

        // integer mode: lone zero and a forbidden e
        write_reg(CFG_REAL_MODE, 6'd0);
        load_text("0");        send_txt();
        load_text("1e2");      send_txt();

        // random strings under a series of settings
        items_sent = 0;
        for (int p = 0; p < N_SETTINGS; p++) begin
            wait_idle(SETTLE_CYCLES);
            case (p)
                0: write_setting(RST_REAL_MODE, RST_MAX_MANT, RST_MAX_EXP);
                1: write_setting(1'b0, 6'd1, 4'd1);
                2: write_setting(1'b1, 6'd63, 4'd15);
                3: write_setting(1'b1, 6'd1, 4'd1);
                4: write_setting(1'b0, 6'd63, 4'd15);
                5: begin
                    write_setting(1'b1, 6'($urandom_range(1, 63)), 4'($urandom_range(1, 15)));
                    write_reg(CFG_IDX_SPARE, 6'($urandom_range(0, 63)));
                end
                default: begin
                    // raw data, a zero limit included now and then
                    write_reg(CFG_REAL_MODE, 6'($urandom_range(0, 63)));
                    write_reg(CFG_MAX_MANT, 6'($urandom_range(0, 63)));
                    write_reg(CFG_MAX_EXP, 6'($urandom_range(0, 63)));
                end
            endcase
            target = RAND_ITEMS * (p + 1) / N_SETTINGS;
            while (items_sent < target) begin
                // halfway through, hold the sender until the result side is drained
                if (items_sent >= target - RAND_ITEMS / (2 * N_SETTINGS)
                    && items_sent < target - RAND_ITEMS / (2 * N_SETTINGS) + 10)
                    wait_idle(0);
                send_random_string();
            end
        end

        wait_idle(END_CYCLES);
        if (sb.fail_cnt == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
